### design/polar_grid_ground_segmentation_unit_defines.svh
// Assertion macros for the polar grid ground segmentation unit.
// Included by the controller, which checks its own control logic.
// No other dependencies.
`ifndef POLAR_GRID_GROUND_SEGMENTATION_UNIT_DEFINES_SVH
`define POLAR_GRID_GROUND_SEGMENTATION_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PGGS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pggs check failed");
`define PGGS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pggs check failed");
`else
`define PGGS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PGGS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### design/pggs_pkg.sv
// Shared types, constants and the arctangent table of the ground segmentation unit.
// Used by every module of the block; depends on nothing.
package pggs_pkg;

	localparam int MAX_ROWS     = 64;
	localparam int MAX_COLS     = 64;
	localparam int CORDIC_STEPS = 16;
	localparam int SQRT_STEPS   = 16;
	localparam int ITER_STEPS   = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
	localparam int ITER_W       = $clog2(ITER_STEPS + 1);
	localparam int CELL_COUNT   = MAX_ROWS * MAX_COLS;
	localparam int IDX_W        = $clog2(CELL_COUNT);
	localparam int ROW_W        = $clog2(MAX_ROWS);
	localparam int COL_W        = $clog2(MAX_COLS);
	localparam int ENTRY_W      = 49;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_CLASS = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_NOP   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CLS_NONGROUND = 2'd0,
		CLS_GROUND    = 2'd1,
		CLS_DROPPED   = 2'd2
	} class_t;

	typedef enum logic [2:0] {
		REG_GRID_ROWS  = 3'd0,
		REG_GRID_COLS  = 3'd1,
		REG_RANGE_MAX  = 3'd2,
		REG_ROW_SCALE  = 3'd3,
		REG_Z_MIN_THR  = 3'd4,
		REG_DIST_SQ    = 3'd5,
		REG_SLOPE_TAN  = 3'd6,
		REG_UNUSED     = 3'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_SQ, S_CHK, S_ITER, S_SCALE, S_CLAMP,
		S_INDEX, S_READ, S_CELL, S_SUM, S_PP, S_EMIT
	} state_t;

	typedef struct packed {
		logic accept;
		logic chk;
		logic step;
		logic scale;
		logic clamp;
		logic index;
		logic read;
		logic upd;
		logic sum;
		logic pp;
		logic emit;
		logic clr_step;
	} cmd_t;

	typedef struct packed {
		logic drop;
		logic is_load;
		logic polar_done;
		logic clr_done;
		logic out_free;
	} stat_t;

	// round(atan(2^-i) * 2^32 / (2 pi))
	function automatic logic [29:0] atan_turn(input logic [4:0] i);
		logic [29:0] v;
		unique case (i)
			5'd0:  v = 30'd536870912;
			5'd1:  v = 30'd316933406;
			5'd2:  v = 30'd167458907;
			5'd3:  v = 30'd85004756;
			5'd4:  v = 30'd42667331;
			5'd5:  v = 30'd21354465;
			5'd6:  v = 30'd10679838;
			5'd7:  v = 30'd5340245;
			5'd8:  v = 30'd2670163;
			5'd9:  v = 30'd1335087;
			5'd10: v = 30'd667544;
			5'd11: v = 30'd333772;
			5'd12: v = 30'd166886;
			5'd13: v = 30'd83443;
			5'd14: v = 30'd41722;
			5'd15: v = 30'd20861;
			5'd16: v = 30'd10430;
			5'd17: v = 30'd5215;
			5'd18: v = 30'd2608;
			5'd19: v = 30'd1304;
			5'd20: v = 30'd652;
			5'd21: v = 30'd326;
			5'd22: v = 30'd163;
			5'd23: v = 30'd81;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

### design/polar_grid_ground_segmentation_unit.sv
// Polar grid ground segmentation unit, top level.
// Per item: accept, square, range check, the 16-step root/CORDIC loop, scale, clamp, index,
// read, then a load updates its cell while a classify goes on through sum and slope product
// to the output register. An out-of-range load ends at the range check, an out-of-range
// classify goes from there to the output register; mode 3 is taken and dropped at accept.
// One item at a time. A clear sweeps the cell store one entry per cycle; the same sweep
// runs after reset (arst_n, asynchronous, active low) and no item is taken meanwhile.
module polar_grid_ground_segmentation_unit (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         mode,
	input  logic signed [15:0] x_coord,
	input  logic signed [15:0] y_coord,
	input  logic signed [15:0] z_coord,
	// config write port
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_wdata,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         point_class,
	output logic [11:0]        cell_index,
	output logic [5:0]         cell_row,
	output logic [5:0]         cell_col
);
	import pggs_pkg::*;

	cmd_t               cmd;
	stat_t              stat;
	logic [31:0]        r2;
	logic signed [15:0] px, py;
	logic [15:0]        range;
	logic [31:0]        azim;
	logic               polar_done;

	// sequencer: accept, square, range check, iterate, bin, cell access, decide
	pggs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.stat     (stat),
		.cmd      (cmd)
	);

	// root and azimuth are started at the range check, stepped in the loop state
	pggs_polar u_polar (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.chk),
		.step   (cmd.step),
		.r2     (r2),
		.x_in   (px),
		.y_in   (py),
		.range  (range),
		.azim   (azim),
		.done   (polar_done)
	);

	// registers, cell store and the output register
	pggs_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.mode        (mode),
		.x_coord     (x_coord),
		.y_coord     (y_coord),
		.z_coord     (z_coord),
		.r2          (r2),
		.px          (px),
		.py          (py),
		.range       (range),
		.azim        (azim),
		.polar_done  (polar_done),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.point_class (point_class),
		.cell_index  (cell_index),
		.cell_row    (cell_row),
		.cell_col    (cell_col)
	);

endmodule

### design/pggs_ctrl.sv
// Controller state machine of the ground segmentation unit.
// Depends on pggs_pkg and the assertion macro header.
`include "polar_grid_ground_segmentation_unit_defines.svh"
module pggs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [1:0]      mode,
	input  pggs_pkg::stat_t stat,
	output pggs_pkg::cmd_t  cmd
);
	import pggs_pkg::*;

	state_t state_q, state_nxt;
	logic   acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign acc      = in_valid && !in_stall;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_done) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				cmd.accept = acc;
				if (acc) begin
					unique case (mode_t'(mode)) inside
						MODE_LOAD, MODE_CLASS: state_nxt = S_SQ;
						MODE_CLEAR:            state_nxt = S_CLEAR;
						default:               state_nxt = S_IDLE;
					endcase
				end
			end
			S_SQ: state_nxt = S_CHK;
			S_CHK: begin
				cmd.chk = 1'b1;
				if (stat.drop) state_nxt = stat.is_load ? S_IDLE : S_EMIT;
				else           state_nxt = S_ITER;
			end
			S_ITER: begin
				cmd.step = 1'b1;
				if (stat.polar_done) state_nxt = S_SCALE;
			end
			S_SCALE: begin
				cmd.scale = 1'b1;
				state_nxt = S_CLAMP;
			end
			S_CLAMP: begin
				cmd.clamp = 1'b1;
				state_nxt = S_INDEX;
			end
			S_INDEX: begin
				cmd.index = 1'b1;
				state_nxt = S_READ;
			end
			S_READ: begin
				cmd.read  = 1'b1;
				state_nxt = S_CELL;
			end
			S_CELL: begin
				cmd.upd   = 1'b1;
				state_nxt = stat.is_load ? S_IDLE : S_SUM;
			end
			S_SUM: begin
				cmd.sum   = 1'b1;
				state_nxt = S_PP;
			end
			S_PP: begin
				cmd.pp    = 1'b1;
				state_nxt = S_EMIT;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	`PGGS_ASSERT_NXT(a_accept_busy, clk, arst_n, acc && mode != MODE_NOP, state_q != S_IDLE)
	`PGGS_ASSERT_NXT(a_iter_exit, clk, arst_n, state_q == S_ITER && stat.polar_done, state_q == S_SCALE)
	`PGGS_ASSERT_NXT(a_clear_exit, clk, arst_n, state_q == S_CLEAR && stat.clr_done, state_q == S_IDLE)
	`PGGS_ASSERT_IMP(a_emit_free, clk, arst_n, cmd.emit, stat.out_free && state_q == S_EMIT)

endmodule

### design/pggs_polar.sv
// Iterative polar unit: integer square root and CORDIC azimuth, one step per cycle while step is high.
// Depends on pggs_pkg.
module pggs_polar (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               step,
	input  logic [31:0]        r2,
	input  logic signed [15:0] x_in,
	input  logic signed [15:0] y_in,
	output logic [15:0]        range,
	output logic [31:0]        azim,
	output logic               done
);
	import pggs_pkg::*;

	logic [ITER_W-1:0]  k_q;
	logic [31:0]        rem_q, root_q;
	logic signed [26:0] cx_q, cy_q;
	logic signed [33:0] ac_q;
	logic               xneg_q, yneg_q, ax0_q, ay0_q;

	logic signed [16:0] xe, ye;
	logic [16:0]        ax, ay;
	logic [31:0]        bitv;
	logic [32:0]        trial;
	logic signed [26:0] sx, sy;
	logic signed [33:0] at;
	logic [31:0]        t;

	always_comb begin
		xe    = {x_in[15], x_in};
		ye    = {y_in[15], y_in};
		ax    = xe[16] ? 17'(-xe) : 17'(xe);
		ay    = ye[16] ? 17'(-ye) : 17'(ye);
		bitv  = 32'd1 << {4'(SQRT_STEPS - 1) - k_q[3:0], 1'b0};
		trial = {1'b0, root_q} + {1'b0, bitv};
		sx    = cx_q >>> k_q;
		sy    = cy_q >>> k_q;
		at    = 34'(atan_turn(5'(k_q)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (start) begin
			k_q <= '0;
		end else if (step && !done) begin
			k_q <= k_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= r2;
			root_q <= '0;
			cx_q   <= {2'b00, ax, 8'h00};
			cy_q   <= {2'b00, ay, 8'h00};
			ac_q   <= '0;
			xneg_q <= x_in[15];
			yneg_q <= y_in[15];
			ax0_q  <= (ax == '0);
			ay0_q  <= (ay == '0);
		end else if (step && !done) begin
			if (k_q < ITER_W'(SQRT_STEPS)) begin
				if ({1'b0, rem_q} >= trial) begin
					rem_q  <= rem_q - trial[31:0];
					root_q <= (root_q >> 1) + bitv;
				end else begin
					root_q <= root_q >> 1;
				end
			end
			if (k_q < ITER_W'(CORDIC_STEPS)) begin
				if (cy_q > 0) begin
					cx_q <= cx_q + sy;
					cy_q <= cy_q - sx;
					ac_q <= ac_q + at;
				end else begin
					cx_q <= cx_q - sy;
					cy_q <= cy_q + sx;
					ac_q <= ac_q - at;
				end
			end
		end
	end

	assign done  = (k_q == ITER_W'(ITER_STEPS));
	assign range = root_q[15:0];

	always_comb begin
		if (ay0_q)                             t = '0;
		else if (ax0_q)                        t = QUARTER_TURN;
		else if (ac_q < 0)                     t = '0;
		else if (ac_q > $signed({2'b00, QUARTER_TURN})) t = QUARTER_TURN;
		else                                   t = ac_q[31:0];
		if (!xneg_q && !yneg_q)     azim = t;
		else if (xneg_q && !yneg_q) azim = HALF_TURN - t;
		else if (xneg_q)            azim = HALF_TURN + t;
		else                        azim = 32'd0 - t;
	end

endmodule

### design/pggs_dp.sv
// Datapath of the ground segmentation unit: config registers, binning,
// cell store with clear sweep, classification and the output register.
// Depends on pggs_pkg; the polar unit feeds range and azimuth.
module pggs_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  pggs_pkg::cmd_t     cmd,
	output pggs_pkg::stat_t    stat,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_wdata,
	input  logic [1:0]         mode,
	input  logic signed [15:0] x_coord,
	input  logic signed [15:0] y_coord,
	input  logic signed [15:0] z_coord,
	output logic [31:0]        r2,
	output logic signed [15:0] px,
	output logic signed [15:0] py,
	input  logic [15:0]        range,
	input  logic [31:0]        azim,
	input  logic               polar_done,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         point_class,
	output logic [11:0]        cell_index,
	output logic [5:0]         cell_row,
	output logic [5:0]         cell_col
);
	import pggs_pkg::*;

	// config
	logic [6:0]         rows_cfg_q, cols_cfg_q;
	logic [15:0]        range_max_q;
	logic [23:0]        row_scale_q, slope_q;
	logic signed [15:0] zthr_q;
	logic [31:0]        dthr_q;

	// item
	logic [1:0]         mode_q;
	logic signed [15:0] x_q, y_q, z_q;
	logic [30:0]        xx_q, yy_q;
	logic [31:0]        rm_q;
	logic               drop_q;
	logic [39:0]        rprod_q;
	logic [38:0]        cprod_q;
	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   clr_q;
	logic [ENTRY_W-1:0] rd_q;
	logic [31:0]        dx2_q, dy2_q, dz2_q;
	logic               cand_q, eq_q, dok_q;
	logic [32:0]        h2_q;
	logic [31:0]        z2_q;
	logic [40:0]        ppl_q;
	logic [39:0]        pph_q;

	logic [ENTRY_W-1:0] mem [CELL_COUNT];

	logic [6:0]         rows, cols;
	logic signed [31:0] sxx, syy;
	logic [15:0]        row_raw;
	logic [6:0]         col_raw;
	logic               rvalid;
	logic signed [15:0] rx, ry, rz;
	logic signed [16:0] dx, dy, dz;
	logic signed [33:0] dx2, dy2, dz2;
	logic [56:0]        sprod;
	logic               slope_ok;
	logic [1:0]         cls;
	logic               out_take;

	// config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q  <= 7'd64;
			cols_cfg_q  <= 7'd64;
			range_max_q <= 16'd20480;
			row_scale_q <= 24'd52429;
			zthr_q      <= -16'sd102;
			dthr_q      <= 32'd4096;
			slope_q     <= 24'd14250;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_GRID_ROWS: rows_cfg_q  <= cfg_wdata[6:0];
				REG_GRID_COLS: cols_cfg_q  <= cfg_wdata[6:0];
				REG_RANGE_MAX: range_max_q <= cfg_wdata[15:0];
				REG_ROW_SCALE: row_scale_q <= cfg_wdata[23:0];
				REG_Z_MIN_THR: zthr_q      <= cfg_wdata[15:0];
				REG_DIST_SQ:   dthr_q      <= cfg_wdata;
				REG_SLOPE_TAN: slope_q     <= cfg_wdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		rows = (rows_cfg_q == 7'd0) ? 7'd1 :
			((rows_cfg_q > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : rows_cfg_q);
		cols = (cols_cfg_q == 7'd0) ? 7'd1 :
			((cols_cfg_q > 7'(MAX_COLS)) ? 7'(MAX_COLS) : cols_cfg_q);
		sxx  = x_q * x_q;
		syy  = y_q * y_q;
		r2   = {1'b0, xx_q} + {1'b0, yy_q};
		px   = x_q;
		py   = y_q;
		row_raw = rprod_q[39:24];
		col_raw = cprod_q[38:32];
		{rvalid, rx, ry, rz} = rd_q;
		dx  = {x_q[15], x_q} - {rx[15], rx};
		dy  = {y_q[15], y_q} - {ry[15], ry};
		dz  = {z_q[15], z_q} - {rz[15], rz};
		dx2 = dx * dx;
		dy2 = dy * dy;
		dz2 = dz * dz;
		sprod    = {pph_q, 17'd0} + {16'd0, ppl_q};
		slope_ok = {9'd0, z2_q, 16'd0} < sprod;
		if (drop_q)                           cls = CLS_DROPPED;
		else if (cand_q && (eq_q || dok_q || slope_ok)) cls = CLS_GROUND;
		else                                  cls = CLS_NONGROUND;
	end

	// item datapath
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q <= mode;
			x_q    <= x_coord;
			y_q    <= y_coord;
			z_q    <= z_coord;
		end
		// squares are taken every cycle; only the one after accept is used
		xx_q <= sxx[30:0];
		yy_q <= syy[30:0];
		rm_q <= range_max_q * range_max_q;
		if (cmd.chk)   drop_q  <= (r2 >= rm_q);
		if (cmd.scale) begin
			rprod_q <= range * row_scale_q;
			cprod_q <= azim * cols;
		end
		if (cmd.clamp) begin
			row_q <= (row_raw > 16'(rows - 7'd1)) ? ROW_W'(rows - 7'd1) : ROW_W'(row_raw);
			col_q <= (col_raw > (cols - 7'd1)) ? COL_W'(cols - 7'd1) : COL_W'(col_raw);
		end
		if (cmd.index) idx_q <= IDX_W'(row_q * cols) + IDX_W'(col_q);
		if (cmd.read)  rd_q  <= mem[idx_q];
		if (cmd.upd) begin
			dx2_q  <= dx2[31:0];
			dy2_q  <= dy2[31:0];
			dz2_q  <= dz2[31:0];
			cand_q <= rvalid && (rz < zthr_q);
			eq_q   <= (dx == '0) && (dy == '0) && (dz == '0);
		end
		if (cmd.sum) begin
			h2_q <= {1'b0, dx2_q} + {1'b0, dy2_q};
			z2_q <= dz2_q;
		end
		if (cmd.pp) begin
			ppl_q <= slope_q * h2_q[16:0];
			pph_q <= slope_q * h2_q[32:17];
			dok_q <= ({1'b0, h2_q} + {2'b0, z2_q}) < {2'b0, dthr_q};
		end
		// single write port: clear sweep or first-lowest update
		if (cmd.clr_step) begin
			mem[clr_q] <= '0;
		end else if (cmd.upd && mode_q == MODE_LOAD && (!rvalid || z_q < rz)) begin
			mem[idx_q] <= {1'b1, x_q, y_q, z_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.accept) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// output register
	assign out_take = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_take) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			point_class <= cls;
			cell_index  <= drop_q ? 12'd0 : 12'(idx_q);
			cell_row    <= drop_q ? 6'd0 : 6'(row_q);
			cell_col    <= drop_q ? 6'd0 : 6'(col_q);
		end
	end

	always_comb begin
		stat.drop       = (r2 >= rm_q);
		stat.is_load    = (mode_q == MODE_LOAD);
		stat.polar_done = polar_done;
		stat.clr_done   = (clr_q == IDX_W'(CELL_COUNT - 1));
		stat.out_free   = !out_valid || !out_stall;
	end

endmodule

### tb/sv/tb_polar_grid_ground_segmentation_unit.sv
// Testbench for the polar grid ground segmentation unit: directed table, then
// random load/classify frames under several register settings and idle patterns.
// Depends on pggs_pkg and the polar_grid_ground_segmentation_unit RTL.
`timescale 1ns / 100ps

module tb_polar_grid_ground_segmentation_unit;
	import pggs_pkg::*;

	// one classify result
	typedef struct packed {
		class_t      cls;
		logic [11:0] idx;
		logic [5:0]  row;
		logic [5:0]  col;
	} seg_result_t;

	// one row of the directed table; chk set means the result is typed in
	typedef struct packed {
		mode_t              m;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic               chk;
		seg_result_t        res;
	} seg_stim_t;

	localparam int N_DIRECTED = 22;
	localparam seg_result_t NONE = '{CLS_NONGROUND, 12'd0, 6'd0, 6'd0};
	localparam seg_result_t DROP = '{CLS_DROPPED, 12'd0, 6'd0, 6'd0};

	localparam seg_stim_t DIRECTED [N_DIRECTED] = '{
		// store empty after reset: non-ground in cell 0
		'{MODE_CLASS, 16'sd256, 16'sd0, 16'sd0, 1'b1, NONE},
		// far corners, dropped
		'{MODE_CLASS, 16'sd32767, 16'sd32767, 16'sd32767, 1'b1, DROP},
		'{MODE_CLASS, -16'sd32768, -16'sd32768, -16'sd32768, 1'b1, DROP},
		'{MODE_LOAD, -16'sd32768, 16'sd32767, -16'sd32768, 1'b0, NONE},
		// lowest point, an equal-z later one, a higher one
		'{MODE_LOAD, 16'sd256, 16'sd0, -16'sd500, 1'b0, NONE},
		'{MODE_LOAD, 16'sd260, 16'sd0, -16'sd500, 1'b0, NONE},
		'{MODE_LOAD, 16'sd258, 16'sd3, 16'sd2000, 1'b0, NONE},
		// axes and quadrants
		'{MODE_LOAD, 16'sd0, 16'sd512, -16'sd400, 1'b0, NONE},
		'{MODE_LOAD, -16'sd512, 16'sd0, -16'sd400, 1'b0, NONE},
		'{MODE_LOAD, 16'sd0, -16'sd512, 16'sd100, 1'b0, NONE},
		'{MODE_LOAD, -16'sd300, -16'sd300, -16'sd200, 1'b0, NONE},
		'{MODE_LOAD, 16'sd300, -16'sd300, -16'sd200, 1'b0, NONE},
		'{MODE_NOP, 16'sd1, 16'sd1, 16'sd1, 1'b0, NONE},
		'{MODE_CLASS, 16'sd256, 16'sd0, -16'sd500, 1'b0, NONE},
		'{MODE_CLASS, 16'sd260, 16'sd0, -16'sd500, 1'b0, NONE},
		'{MODE_CLASS, 16'sd258, 16'sd3, 16'sd2000, 1'b0, NONE},
		'{MODE_CLASS, 16'sd0, 16'sd512, -16'sd400, 1'b0, NONE},
		'{MODE_CLASS, -16'sd512, 16'sd0, -16'sd380, 1'b0, NONE},
		'{MODE_CLASS, 16'sd0, -16'sd512, 16'sd100, 1'b0, NONE},
		'{MODE_CLASS, -16'sd310, -16'sd290, -16'sd150, 1'b0, NONE},
		// cleared store: non-ground again
		'{MODE_CLEAR, 16'sd0, 16'sd0, 16'sd0, 1'b0, NONE},
		'{MODE_CLASS, 16'sd256, 16'sd0, -16'sd500, 1'b1, NONE}
	};

	localparam longint ATAN_TURNS [24] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         in_mode;
	logic signed [15:0] x_coord, y_coord, z_coord;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_wdata;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         point_class;
	logic [11:0]        cell_index;
	logic [5:0]         cell_row, cell_col;

	polar_grid_ground_segmentation_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .mode(in_mode),
		.x_coord(x_coord), .y_coord(y_coord), .z_coord(z_coord),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.out_valid(out_valid), .out_stall(out_stall),
		.point_class(point_class), .cell_index(cell_index),
		.cell_row(cell_row), .cell_col(cell_col)
	);

	// shadow registers
	logic [6:0]         n_rows, n_cols;
	logic [15:0]        range_lim;
	logic [23:0]        ring_scale;
	logic signed [15:0] z_floor_thr;
	logic [31:0]        near_sq_thr;
	logic [23:0]        slope_sq;

	// shadow of the cell store: valid flag and lowest point per cell
	bit                 low_ok [CELL_COUNT];
	logic signed [15:0] low_x [CELL_COUNT], low_y [CELL_COUNT], low_z [CELL_COUNT];

	seg_result_t pending_results [$];
	int          err_count;
	int          send_idle_pct, stall_pct;

	initial begin
		clk = 1'b0;
	end

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// global watchdog: far beyond the slowest legal run
	initial begin
		#40_000_000;
		$display("FAIL polar_grid_ground_segmentation_unit");
		$finish;
	end

	task automatic report(input string what);
		if (err_count < 40)
			$display("mismatch @%0t: %s", $realtime, what);
		err_count++;
	endtask

	function automatic longint unsigned root_floor(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 32;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// bearing as a 32-bit fraction of a turn, counter-clockwise from +x
	function automatic logic [31:0] bearing(input longint x, input longint y);
		longint ax, ay, cx, cy, acc, th, sx, sy;
		logic [31:0] t;
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		if (ay == 0)
			th = 0;
		else if (ax == 0)
			th = longint'(QUARTER_TURN);
		else begin
			cx = ax * 256;
			cy = ay * 256;
			acc = 0;
			for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
				sx = cx >>> i;
				sy = cy >>> i;
				if (cy > 0) begin
					cx += sy;
					cy -= sx;
					acc += ATAN_TURNS[i];
				end else begin
					cx -= sy;
					cy += sx;
					acc -= ATAN_TURNS[i];
				end
			end
			th = (acc < 0) ? 0 : ((acc > longint'(QUARTER_TURN)) ? longint'(QUARTER_TURN) : acc);
		end
		t = th[31:0];
		if (x >= 0 && y >= 0)
			return t;
		if (x < 0 && y >= 0)
			return HALF_TURN - t;
		if (x < 0)
			return HALF_TURN + t;
		return 32'd0 - t;
	endfunction

	// updates the shadow store; returns 1 with the result when one is due
	function automatic bit segment_point(input mode_t m, input logic signed [15:0] x,
			input logic signed [15:0] y, input logic signed [15:0] z,
			output seg_result_t res);
		longint unsigned r2, rm, rows, cols, row, col, idx, h2, z2;
		longint dx, dy, dz;
		res = NONE;
		if (m == MODE_CLEAR) begin
			foreach (low_ok[i])
				low_ok[i] = 1'b0;
			return 1'b0;
		end
		if (m == MODE_NOP)
			return 1'b0;
		rows = (n_rows < 1) ? 1 : ((n_rows > MAX_ROWS) ? MAX_ROWS : n_rows);
		cols = (n_cols < 1) ? 1 : ((n_cols > MAX_COLS) ? MAX_COLS : n_cols);
		r2 = longint'(x) * x + longint'(y) * y;
		rm = longint'(range_lim) * range_lim;
		if (r2 >= rm) begin
			if (m == MODE_LOAD)
				return 1'b0;
			res = DROP;
			return 1'b1;
		end
		row = (root_floor(r2) * ring_scale) >> 24;
		if (row > rows - 1)
			row = rows - 1;
		col = (longint'(bearing(x, y)) * cols) >> 32;
		if (col > cols - 1)
			col = cols - 1;
		idx = row * cols + col;
		if (idx >= CELL_COUNT)
			idx = CELL_COUNT - 1;
		if (m == MODE_LOAD) begin
			if (!low_ok[idx] || z < low_z[idx]) begin
				low_ok[idx] = 1'b1;
				low_x[idx] = x;
				low_y[idx] = y;
				low_z[idx] = z;
			end
			return 1'b0;
		end
		res.cls = CLS_NONGROUND;
		if (low_ok[idx] && low_z[idx] < z_floor_thr) begin
			dx = longint'(x) - low_x[idx];
			dy = longint'(y) - low_y[idx];
			dz = longint'(z) - low_z[idx];
			h2 = dx * dx + dy * dy;
			z2 = dz * dz;
			if (dx == 0 && dy == 0 && dz == 0)
				res.cls = CLS_GROUND;
			else if (h2 + z2 < near_sq_thr)
				res.cls = CLS_GROUND;
			else if ((z2 << 16) < longint'(slope_sq) * h2)
				res.cls = CLS_GROUND;
		end
		res.idx = idx[11:0];
		res.row = row[5:0];
		res.col = col[5:0];
		return 1'b1;
	endfunction

	// result side: random stall, in-order compare
	always @(posedge clk or negedge arst_n) begin
		seg_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					report("result with nothing expected");
				end else begin
					want = pending_results.pop_front();
					if (point_class !== want.cls)
						report($sformatf("point_class %0d want %0d", point_class, want.cls));
					if (cell_index !== want.idx)
						report($sformatf("cell_index %0d want %0d", cell_index, want.idx));
					if (cell_row !== want.row)
						report($sformatf("cell_row %0d want %0d", cell_row, want.row));
					if (cell_col !== want.col)
						report($sformatf("cell_col %0d want %0d", cell_col, want.col));
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// one register write; write enable goes low again between writes, keeping its edges apart
	task automatic write_reg(input reg_idx_t r, input logic [31:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= r;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (r)
			REG_GRID_ROWS: n_rows      = v[6:0];
			REG_GRID_COLS: n_cols      = v[6:0];
			REG_RANGE_MAX: range_lim   = v[15:0];
			REG_ROW_SCALE: ring_scale  = v[23:0];
			REG_Z_MIN_THR: z_floor_thr = v[15:0];
			REG_DIST_SQ:   near_sq_thr = v;
			REG_SLOPE_TAN: slope_sq    = v[23:0];
			default: ;
		endcase
	endtask

	// one item through the input handshake; the shadow model runs on accept
	task automatic send_point(input mode_t m, input logic signed [15:0] x,
			input logic signed [15:0] y, input logic signed [15:0] z,
			input bit typed, input seg_result_t typed_res);
		seg_result_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_mode  <= m;
		x_coord  <= x;
		y_coord  <= y;
		z_coord  <= z;
		do
			@(posedge clk);
		while (in_stall);
		if (segment_point(m, x, y, z, res))
			pending_results = {pending_results, (typed ? typed_res : res)};
	endtask

	// drain all results, then let a clear sweep finish
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4200) @(posedge clk);
	endtask

	function automatic logic signed [15:0] near_coord(input int span);
		return 16'(int'($urandom_range(2 * span)) - span);
	endfunction

	// random frames: clear, loads, classifies of the same or nearby points, a little noise
	task automatic run_frames(input int n_items, input int span);
		logic signed [15:0] px [$], py [$], pz [$];
		int done, n, k;
		done = 0;
		while (done < n_items) begin
			px.delete();
			py.delete();
			pz.delete();
			send_point(MODE_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), 0, NONE);
			n = $urandom_range(6, 14);
			for (int i = 0; i < n; i++) begin
				px = {px, near_coord(span)};
				py = {py, near_coord(span)};
				pz = {pz, near_coord(400) - 16'sd150};
				send_point(MODE_LOAD, px[i], py[i], pz[i], 0, NONE);
			end
			for (int i = 0; i < n + 2; i++) begin
				k = $urandom_range(n - 1);
				if ($urandom_range(3) == 0)
					send_point(MODE_CLASS, px[k] + near_coord(40), py[k] + near_coord(40),
						pz[k] + near_coord(60), 0, NONE);
				else
					send_point(MODE_CLASS, px[k], py[k], pz[k], 0, NONE);
			end
			// noise: any mode, any coordinates
			for (int i = 0; i < 2; i++)
				send_point(mode_t'($urandom_range(3)), 16'($urandom), 16'($urandom),
					16'($urandom), 0, NONE);
			done += 2 * n + 5;
		end
	endtask

	initial begin
		err_count     = 0;
		send_idle_pct = 0;
		stall_pct     = 0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_mode       = MODE_NOP;
		x_coord       = '0;
		y_coord       = '0;
		z_coord       = '0;
		cfg_we        = 1'b0;
		cfg_index     = REG_GRID_ROWS;
		cfg_wdata     = '0;
		n_rows        = 7'd64;
		n_cols        = 7'd64;
		range_lim     = 16'd20480;
		ring_scale    = 24'd52429;
		z_floor_thr   = -16'sd102;
		near_sq_thr   = 32'd4096;
		slope_sq      = 24'd14250;
		foreach (low_ok[i])
			low_ok[i] = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed part under reset settings, no idling
		for (int i = 0; i < N_DIRECTED; i++)
			send_point(DIRECTED[i].m, DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].z,
				DIRECTED[i].chk, DIRECTED[i].res);
		run_frames(60, 3000);

		// small grid, sender idling
		settle();
		write_reg(REG_GRID_ROWS, 32'd16);
		write_reg(REG_GRID_COLS, 32'd8);
		write_reg(REG_RANGE_MAX, 32'd8000);
		write_reg(REG_ROW_SCALE, 32'd33554);
		write_reg(REG_Z_MIN_THR, 32'hFFFF_FFCE);
		write_reg(REG_DIST_SQ, 32'd20000);
		write_reg(REG_SLOPE_TAN, 32'd65536);
		send_idle_pct = 69;
		run_frames(35, 6000);
		// hold off until every result is home, then carry on
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
		run_frames(35, 6000);

		// mostly upper extremes, receiver stalling
		settle();
		write_reg(REG_GRID_ROWS, 32'd127);
		write_reg(REG_GRID_COLS, 32'd1);
		write_reg(REG_RANGE_MAX, 32'd65535);
		write_reg(REG_ROW_SCALE, 32'hFF_FFFF);
		write_reg(REG_Z_MIN_THR, 32'd32767);
		write_reg(REG_DIST_SQ, 32'hFFFF_FFFF);
		write_reg(REG_SLOPE_TAN, 32'd0);
		send_idle_pct = 0;
		stall_pct = 69;
		run_frames(70, 30000);

		// mostly lower extremes, both sides idling
		settle();
		write_reg(REG_GRID_ROWS, 32'd0);
		write_reg(REG_GRID_COLS, 32'd127);
		write_reg(REG_RANGE_MAX, 32'd46341);
		write_reg(REG_ROW_SCALE, 32'd0);
		write_reg(REG_Z_MIN_THR, 32'h0000_8000);
		write_reg(REG_DIST_SQ, 32'd0);
		write_reg(REG_SLOPE_TAN, 32'hFF_FFFF);
		send_idle_pct = 28;
		stall_pct = 28;
		run_frames(45, 20000);

		// tiny range limit: nearly everything dropped
		settle();
		write_reg(REG_RANGE_MAX, 32'd1);
		write_reg(REG_Z_MIN_THR, 32'd32767);
		run_frames(15, 20);

		// back to reset values, no idling
		settle();
		write_reg(REG_GRID_ROWS, 32'd64);
		write_reg(REG_GRID_COLS, 32'd64);
		write_reg(REG_RANGE_MAX, 32'd20480);
		write_reg(REG_ROW_SCALE, 32'd52429);
		write_reg(REG_Z_MIN_THR, 32'hFFFF_FF9A);
		write_reg(REG_DIST_SQ, 32'd4096);
		write_reg(REG_SLOPE_TAN, 32'd14250);
		send_idle_pct = 0;
		stall_pct = 0;
		run_frames(70, 5000);

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (err_count == 0)
			$display("PASS polar_grid_ground_segmentation_unit");
		else
			$display("FAIL polar_grid_ground_segmentation_unit");
		$finish;
	end

endmodule

### files.f
+incdir+design
design/pggs_pkg.sv
design/pggs_ctrl.sv
design/pggs_polar.sv
design/pggs_dp.sv
design/polar_grid_ground_segmentation_unit.sv
tb/sv/tb_polar_grid_ground_segmentation_unit.sv
